### design/websocket_frame_deframer_core_macros.svh
// Assertion helpers for the design files; only wsfd_parser.sv includes them.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define WSFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wsfd assertion failed");

// Next-cycle implication, disabled while reset is held.
`define WSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wsfd assertion failed");

`endif

### design/wsfd_pkg.sv
package wsfd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT_HI  = 3'd2,
        PH_EXT_LO  = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_DISCARD = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
    localparam logic [1:0] KEY_LAST_IDX   = 2'd3;

    typedef struct packed {
        logic [7:0]  out_byte;
        t_kind       result_kind;
        logic [3:0]  frame_opcode;
        logic [15:0] frame_length;
        logic        last_byte;
    } t_result;

endpackage

### design/wsfd_if.sv
interface wsfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface wsfd_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  result_kind;
    logic [3:0]  frame_opcode;
    logic [15:0] frame_length;
    logic        last_byte;

    modport source (output valid, output out_byte, output result_kind, output frame_opcode,
                    output frame_length, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input result_kind, input frame_opcode,
                    input frame_length, input last_byte, output ready);
endinterface

### design/wsfd_in_stage.sv
module wsfd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wsfd_byte_if.sink  i_in,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_data_byte,
    output logic       o_frame_start
);
    logic       r_valid;
    logic [7:0] r_data_byte;
    logic       r_frame_start;
    logic       w_take;

    assign i_in.ready = !r_valid || i_advance;
    assign w_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data_byte   <= i_in.data_byte;
            r_frame_start <= i_in.frame_start;
        end
    end

    assign o_valid       = r_valid;
    assign o_data_byte   = r_data_byte;
    assign o_frame_start = r_frame_start;
endmodule

### design/wsfd_parser.sv
`include "websocket_frame_deframer_core_macros.svh"

module wsfd_parser
    import wsfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_start,
    output logic       o_res_valid,
    output t_result    o_res
);
    t_phase      r_phase,  n_phase;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_masked, n_masked;
    logic [15:0] r_len,    n_len;
    logic [31:0] r_key,    n_key;
    logic [15:0] r_cnt,    n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_opcode <= '0;
            r_masked <= 1'b0;
            r_len    <= '0;
            r_key    <= '0;
            r_cnt    <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
            r_len    <= n_len;
            r_key    <= n_key;
            r_cnt    <= n_cnt;
        end
    end

    always_comb begin
        logic [15:0] cnt_inc;
        logic [7:0]  key_byte;
        logic        hdr_done;
        logic        is_last;

        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_masked    = r_masked;
        n_len       = r_len;
        n_key       = r_key;
        n_cnt       = r_cnt;
        hdr_done    = 1'b0;
        cnt_inc     = r_cnt + 16'd1;
        key_byte    = r_key[{r_cnt[1:0], 3'b000} +: 8];
        is_last     = (cnt_inc >= r_len);
        o_res_valid = 1'b0;
        o_res       = '{out_byte: '0, result_kind: KIND_PAYLOAD, frame_opcode: r_opcode,
                        frame_length: '0, last_byte: 1'b0};

        if (i_frame_start) begin
            // resync: abandon any frame in progress
            n_opcode = i_data_byte[3:0];
            n_phase  = PH_HDR1;
        end else begin
            case (r_phase)
                PH_HDR0: begin
                    n_opcode = i_data_byte[3:0];
                    n_phase  = PH_HDR1;
                end
                PH_HDR1: begin
                    n_masked = i_data_byte[7];
                    if (i_data_byte[6:0] == LEN_CODE_EXT64) begin
                        n_phase                = PH_DISCARD;
                        o_res_valid            = 1'b1;
                        o_res.result_kind      = KIND_ERROR;
                        o_res.last_byte        = 1'b1;
                    end else if (i_data_byte[6:0] == LEN_CODE_EXT16) begin
                        n_phase = PH_EXT_HI;
                    end else begin
                        n_len    = {9'd0, i_data_byte[6:0]};
                        hdr_done = 1'b1;
                    end
                end
                PH_EXT_HI: begin
                    n_len   = {i_data_byte, 8'h00};
                    n_phase = PH_EXT_LO;
                end
                PH_EXT_LO: begin
                    n_len    = {r_len[15:8], i_data_byte};
                    hdr_done = 1'b1;
                end
                PH_KEY: begin
                    n_key[{r_cnt[1:0], 3'b000} +: 8] = i_data_byte;
                    n_cnt = cnt_inc;
                    if (r_cnt[1:0] == KEY_LAST_IDX) begin
                        n_cnt = '0;
                        if (r_len == 16'd0) begin
                            n_phase           = PH_HDR0;
                            o_res_valid       = 1'b1;
                            o_res.result_kind = KIND_EMPTY;
                            o_res.last_byte   = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    o_res_valid        = 1'b1;
                    o_res.out_byte     = i_data_byte ^ (r_masked ? key_byte : 8'h00);
                    o_res.frame_length = r_len;
                    o_res.last_byte    = is_last;
                    if (is_last) begin
                        n_cnt   = '0;
                        n_phase = PH_HDR0;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                PH_DISCARD: begin
                    // drop until the next frame start
                end
                default: begin
                    n_opcode = i_data_byte[3:0];
                    n_phase  = PH_HDR1;
                end
            endcase
        end

        if (hdr_done) begin
            n_cnt = '0;
            if (n_masked) begin
                n_phase = PH_KEY;
            end else if (n_len == 16'd0) begin
                n_phase           = PH_HDR0;
                o_res_valid       = 1'b1;
                o_res.result_kind = KIND_EMPTY;
                o_res.last_byte   = 1'b1;
            end else begin
                n_phase = PH_PAYLOAD;
            end
        end
    end

    `WSFD_ASSERT_NEXT(a_start_resyncs, i_clk, i_rst_n, i_step && i_frame_start, r_phase == PH_HDR1)
    `WSFD_ASSERT_NOW(a_payload_cnt_in_range, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_cnt < r_len)
    `WSFD_ASSERT_NOW(a_key_cnt_in_range, i_clk, i_rst_n, r_phase == PH_KEY, r_cnt < 16'd4)
    `WSFD_ASSERT_NOW(a_non_payload_is_last, i_clk, i_rst_n,
                     o_res_valid && (o_res.result_kind != KIND_PAYLOAD),
                     o_res.last_byte && (o_res.frame_length == 16'd0) && (o_res.out_byte == 8'd0))
endmodule

### design/wsfd_out_stage.sv
module wsfd_out_stage
    import wsfd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_result       i_res,
    output logic          o_slot_ready,
    wsfd_result_if.source o_out
);
    logic    r_valid;
    t_result r_res;

    assign o_slot_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.out_byte     = r_res.out_byte;
    assign o_out.result_kind  = r_res.result_kind;
    assign o_out.frame_opcode = r_res.frame_opcode;
    assign o_out.frame_length = r_res.frame_length;
    assign o_out.last_byte    = r_res.last_byte;
endmodule

### design/websocket_frame_deframer_core.sv
// Channel   Dir  Payload                                                      Accept
// i_in      in   data_byte[8], frame_start[1]                                 valid && ready
// o_out     out  out_byte[8], result_kind[2], frame_opcode[4],                valid && ready
//                frame_length[16], last_byte[1]
//
// One byte per cycle sustained while o_out is not stalled; a result is presented on o_out
// from the result register, which is loaded from the input register. The parse state
// register updates once per byte; the input and result registers each hold one item.
// Reset (i_rst_n low, synchronous) returns the parser to the first header byte.
// A stalled o_out holds the result register, which stops the input register and
// then i_in.ready; bytes that make no result still need a free result slot.
module websocket_frame_deframer_core
    import wsfd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    wsfd_byte_if.sink     i_in,
    wsfd_result_if.source o_out
);
    logic       w_stg_valid;
    logic [7:0] w_stg_byte;
    logic       w_stg_start;
    logic       w_slot_ready;
    logic       w_step;
    logic       w_res_valid;
    t_result    w_res;

    assign w_step = w_stg_valid && w_slot_ready;

    wsfd_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_advance     (w_step),
        .o_valid       (w_stg_valid),
        .o_data_byte   (w_stg_byte),
        .o_frame_start (w_stg_start)
    );

    wsfd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_data_byte   (w_stg_byte),
        .i_frame_start (w_stg_start),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    wsfd_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_step && w_res_valid),
        .i_res        (w_res),
        .o_slot_ready (w_slot_ready),
        .o_out        (o_out)
    );
endmodule
